### hw/rtl/dtti_pkg.sv
// Package for the decimal text to integer parser.
// Holds the byte codes and the overflow guard used by the datapath.
// No dependencies.
package dtti_pkg;

    localparam int unsigned MagWidth   = 63;
    localparam int unsigned ValueWidth = 64;

    localparam logic [7:0] TERM_BYTE  = 8'h00;
    localparam logic [7:0] MINUS_BYTE = 8'h2D;
    localparam logic [7:0] LEAD_BYTE  = 8'h82;
    localparam logic [7:0] ASCII_LOW  = 8'h30;
    localparam logic [7:0] ASCII_HIGH = 8'h39;
    localparam logic [7:0] WIDE_LOW   = 8'h4F;
    localparam logic [7:0] WIDE_HIGH  = 8'h58;

    localparam logic [MagWidth-1:0] GUARD_LIMIT = 63'd922337203685477579;

endpackage

### hw/rtl/decimal_text_to_int64.sv
// A terminating zero byte goes to the byte register, then its value to the result
// register. Throughput: one byte per cycle; the accumulator update (times ten plus
// digit) is a single adder stage between the byte register and the state registers.
// A byte waits in the byte register only while a terminator finds the result
// register full and stalled. Reset clears all control and parser state at once.
module decimal_text_to_int64 (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         text_byte,
    input  logic                               text_valid,
    output logic                               text_stall,
    output logic signed [dtti_pkg::ValueWidth-1:0] value,
    output logic                               value_valid,
    input  logic                               value_stall
);
    import dtti_pkg::*;

    logic                  byte_valid_reg;
    logic [7:0]            byte_reg;
    logic                  out_valid_reg;
    logic [ValueWidth-1:0] value_reg;

    logic [MagWidth-1:0]   magnitude_reg, magnitude_next;
    logic                  negative_reg, negative_next;
    logic                  lead_pending_reg, lead_pending_next;
    logic                  halted_reg, halted_next;

    logic                  is_term;
    logic                  out_free;
    logic                  proceed;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [7:0]            wide_offset;
    logic [MagWidth+1:0]   mag_x10;
    logic [MagWidth-1:0]   mag_acc;
    logic [ValueWidth-1:0] mag_ext;

    assign is_term  = (byte_reg == TERM_BYTE);
    assign out_free = !out_valid_reg || !value_stall;
    // Only a terminator needs room in the result register.
    assign proceed  = byte_valid_reg && (!is_term || out_free);
    assign text_stall = byte_valid_reg && !proceed;

    assign wide_offset = byte_reg - WIDE_LOW;
    assign mag_x10 = ({2'b00, magnitude_reg} << 3) + ({2'b00, magnitude_reg} << 1);
    assign mag_acc = mag_x10[MagWidth-1:0] + {{(MagWidth-4){1'b0}}, digit};
    assign mag_ext = {1'b0, magnitude_reg};

    always_comb
    begin
        if (lead_pending_reg)
        begin
            is_digit = (byte_reg >= WIDE_LOW) && (byte_reg <= WIDE_HIGH);
            digit    = wide_offset[3:0];
        end
        else
        begin
            is_digit = (byte_reg >= ASCII_LOW) && (byte_reg <= ASCII_HIGH);
            digit    = byte_reg[3:0];
        end
    end

    always_comb
    begin
        magnitude_next    = magnitude_reg;
        negative_next     = negative_reg;
        lead_pending_next = lead_pending_reg;
        halted_next       = halted_reg;
        if (is_term)
        begin
            magnitude_next    = '0;
            negative_next     = 1'b0;
            lead_pending_next = 1'b0;
            halted_next       = 1'b0;
        end
        else if (!halted_reg)
        begin
            // The byte after a lead byte is always consumed, digit or not.
            if (lead_pending_reg)
            begin
                lead_pending_next = 1'b0;
            end
            else if (byte_reg == MINUS_BYTE)
            begin
                negative_next = 1'b1;
            end
            else if (byte_reg == LEAD_BYTE)
            begin
                lead_pending_next = 1'b1;
            end
            if (is_digit)
            begin
                if (magnitude_reg > GUARD_LIMIT)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    magnitude_next = mag_acc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            magnitude_reg    <= '0;
            negative_reg     <= 1'b0;
            lead_pending_reg <= 1'b0;
            halted_reg       <= 1'b0;
        end
        else
        begin
            if (!byte_valid_reg || proceed)
            begin
                byte_valid_reg <= text_valid;
            end
            if (proceed)
            begin
                magnitude_reg    <= magnitude_next;
                negative_reg     <= negative_next;
                lead_pending_reg <= lead_pending_next;
                halted_reg       <= halted_next;
            end
            if (proceed && is_term)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!value_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_valid_reg || proceed)
        begin
            byte_reg <= text_byte;
        end
        if (proceed && is_term)
        begin
            value_reg <= negative_reg ? (~mag_ext + 64'd1) : mag_ext;
        end
    end

    assign value       = value_reg;
    assign value_valid = out_valid_reg;

endmodule

### hw/rtl/dtti_checker.sv
// Port-level checks for the decimal text to integer parser.
// Depends on dtti_pkg and is bound to decimal_text_to_int64.
module dtti_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic [7:0]                         text_byte,
    input logic                               text_valid,
    input logic                               text_stall,
    input logic signed [dtti_pkg::ValueWidth-1:0] value,
    input logic                               value_valid,
    input logic                               value_stall
);
    import dtti_pkg::*;

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && value_stall |=> value_valid && $stable(value))
        else $error("stalled result changed");

    // A fresh result must be preceded by a terminator transfer.
    a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(value_valid) |-> $past(text_valid && !text_stall && text_byte == TERM_BYTE, 2))
        else $error("result without a terminator");

    // Input back-pressure only arises from a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> value_valid && value_stall)
        else $error("input stalled with room at the output");

    // The overflow guard keeps the magnitude below that of the most negative value.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid |-> value != {1'b1, {(ValueWidth-1){1'b0}}})
        else $error("result out of range");

endmodule

bind decimal_text_to_int64 dtti_checker u_dtti_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .text_byte   (text_byte),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .value       (value),
    .value_valid (value_valid),
    .value_stall (value_stall)
);

### bench/tb_decimal_text_to_int64.sv
// Self-checking testbench for decimal_text_to_int64: directed and random byte strings,
// a queue-fed driver, a checking monitor and an in-bench model of the digit accumulator.
// Depends on dtti_pkg and the decimal_text_to_int64 RTL.
module tb_decimal_text_to_int64;
    timeunit 1ns;
    timeprecision 1ps;

    import dtti_pkg::*;

    typedef struct {
        logic [7:0]  code;
        int unsigned gap;
    } text_slot_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic [7:0]                    text_byte = 8'h00;
    logic                          text_valid = 1'b0;
    logic                          text_stall;
    logic signed [ValueWidth-1:0]  value;
    logic                          value_valid;
    logic                          value_stall = 1'b0;

    text_slot_t                    pending_bytes[$];
    logic signed [ValueWidth-1:0]  expected_values[$];

    // Model of the parser state, advanced on every accepted byte.
    logic [MagWidth-1:0]           acc_mag = '0;
    bit                            acc_neg = 1'b0;
    bit                            acc_lead = 1'b0;
    bit                            acc_halted = 1'b0;

    text_slot_t                    cur_slot;
    bit                            have_slot = 1'b0;
    int unsigned                   wait_left = 0;
    int unsigned                   gap_max = 0;
    int unsigned                   total_bytes = 0;
    int unsigned                   bytes_sent = 0;
    int unsigned                   results_seen = 0;
    int unsigned                   strings_parsed = 0;
    int unsigned                   negative_strings = 0;
    int unsigned                   guarded_strings = 0;
    int unsigned                   input_stall_cycles = 0;
    int unsigned                   error_count = 0;
    int unsigned                   rx_hold = 0;
    bit                            rx_calm = 1'b0;
    int unsigned                   squeeze_left = 0;
    bit                            squeeze_done = 1'b0;

    decimal_text_to_int64 DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_byte),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .value       (value),
        .value_valid (value_valid),
        .value_stall (value_stall)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d of %0d bytes sent.", bytes_sent, total_bytes);
        $display("tb_decimal_text_to_int64: FAIL");
        $finish;
    end

    task automatic push_code(input logic [7:0] code);
        text_slot_t slot;
        begin
            slot.code = code;
            slot.gap  = $urandom_range(0, gap_max);
            pending_bytes.push_back(slot);
            total_bytes++;
        end
    endtask

    task automatic push_digit(input int unsigned digit, input bit wide);
        begin
            if (wide)
            begin
                push_code(LEAD_BYTE);
                push_code(8'(WIDE_LOW + digit));
            end
            else
            begin
                push_code(8'(ASCII_LOW + digit));
            end
        end
    endtask

    // Advances the accumulator model by one byte; a terminator yields the expected value.
    task automatic parse_byte(input logic [7:0] code);
        logic [ValueWidth-1:0] wide_mag;
        bit                    have_digit;
        logic [3:0]            digit;
        begin
            have_digit = 1'b0;
            digit = '0;
            if (code == TERM_BYTE)
            begin
                wide_mag = {1'b0, acc_mag};
                expected_values.push_back(acc_neg ? -wide_mag : wide_mag);
                strings_parsed++;
                if (acc_neg)
                    negative_strings++;
                if (acc_halted)
                    guarded_strings++;
                acc_mag = '0;
                acc_neg = 1'b0;
                acc_lead = 1'b0;
                acc_halted = 1'b0;
            end
            else if (!acc_halted)
            begin
                if (acc_lead)
                begin
                    // The byte after a lead byte is swallowed whatever it is.
                    acc_lead = 1'b0;
                    if (code >= WIDE_LOW && code <= WIDE_HIGH)
                    begin
                        have_digit = 1'b1;
                        digit = 4'(code - WIDE_LOW);
                    end
                end
                else if (code == MINUS_BYTE)
                    acc_neg = 1'b1;
                else if (code == LEAD_BYTE)
                    acc_lead = 1'b1;
                else if (code >= ASCII_LOW && code <= ASCII_HIGH)
                begin
                    have_digit = 1'b1;
                    digit = 4'(code - ASCII_LOW);
                end
                if (have_digit)
                begin
                    if (acc_mag > GUARD_LIMIT)
                        acc_halted = 1'b1;
                    else
                        acc_mag = acc_mag * 10 + digit;
                end
            end
        end
    endtask

    // Sender: the next byte waits out its own gap, and a stalled byte is held as it is.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_byte  <= 8'h00;
        end
        else
        begin
            if (text_valid && !text_stall)
            begin
                parse_byte(text_byte);
                bytes_sent <= bytes_sent + 1;
            end
            if (text_valid && text_stall)
            begin
                input_stall_cycles++;
            end
            else
            begin
                if (!have_slot && pending_bytes.size() != 0)
                begin
                    cur_slot = pending_bytes.pop_front();
                    have_slot = 1'b1;
                    wait_left = cur_slot.gap;
                end
                if (have_slot && wait_left == 0)
                begin
                    text_valid <= 1'b1;
                    text_byte  <= cur_slot.code;
                    have_slot = 1'b0;
                end
                else
                begin
                    text_valid <= 1'b0;
                    if (have_slot)
                        wait_left--;
                end
            end
        end
    end

    // Receiver: checks each transfer, then draws how long to hold off before the next one.
    always @(posedge clk or negedge rst_n)
    begin : value_side
        int unsigned                  next_hold;
        logic signed [ValueWidth-1:0] want;
        if (!rst_n)
        begin
            rx_hold     <= 0;
            value_stall <= 1'b0;
        end
        else
        begin
            next_hold = (rx_hold != 0) ? rx_hold - 1 : 0;
            if (value_valid && !value_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_values.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Value %0d arrived with nothing expected.", value);
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (value !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("Value mismatch: expected %0d, got %0d.", want, value);
                    end
                end
                next_hold = rx_calm ? 0 : $urandom_range(0, 18);
                if (results_seen % 12 == 11)
                    rx_calm = !rx_calm;
            end
            rx_hold     <= next_hold;
            value_stall <= (next_hold != 0) || (squeeze_left != 0);
        end
    end

    // A single long hold-off on the result side, so that the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            squeeze_left <= 0;
            squeeze_done <= 1'b0;
        end
        else if (!squeeze_done && results_seen == 20)
        begin
            squeeze_left <= 300;
            squeeze_done <= 1'b1;
        end
        else if (squeeze_left != 0)
        begin
            squeeze_left <= squeeze_left - 1;
        end
    end

    initial
    begin : run_control
        string       guard_text;
        byte         ch;
        int unsigned len;
        int unsigned neg_at;
        int unsigned drain;

        guard_text = "922337203685477579";

        // Directed strings: empty, zero, signs, lead-byte corner cases and ignored bytes.
        gap_max = 0;
        push_code(TERM_BYTE);
        push_code(ASCII_LOW);
        push_code(TERM_BYTE);
        push_code(MINUS_BYTE);
        push_digit(9, 1'b1);
        push_code(TERM_BYTE);
        push_code(LEAD_BYTE);
        push_code(TERM_BYTE);
        push_code(TERM_BYTE);
        gap_max = 18;
        push_code(LEAD_BYTE);
        push_code(MINUS_BYTE);
        push_code(8'(ASCII_LOW + 5));
        push_code(TERM_BYTE);
        push_code(LEAD_BYTE);
        push_code(LEAD_BYTE);
        push_code(WIDE_LOW);
        push_code(TERM_BYTE);
        push_code(LEAD_BYTE);
        push_code(8'(ASCII_LOW + 7));
        push_code(8'hFF);
        push_code(8'(WIDE_HIGH + 1));
        push_code(8'(WIDE_LOW - 1));
        push_code(8'(ASCII_LOW + 3));
        push_code(TERM_BYTE);

        while (total_bytes < 525)
        begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        case ($urandom_range(0, 5))
                            0: push_code(8'(ASCII_LOW + $urandom_range(0, 9)));
                            1: push_digit($urandom_range(0, 9), 1'b1);
                            2: push_code(MINUS_BYTE);
                            3: push_code(LEAD_BYTE);
                            4: push_code(8'(WIDE_LOW + $urandom_range(0, 9)));
                            default: push_code(8'($urandom_range(1, 255)));
                        endcase
                    end
                end
                3, 4, 5:
                begin
                    len = $urandom_range(12, 24);
                    neg_at = $urandom_range(0, 40);
                    for (int i = 0; i < len; i++)
                    begin
                        if (i == neg_at)
                            push_code(MINUS_BYTE);
                        if ($urandom_range(0, 11) == 0)
                            push_code(8'($urandom_range(1, 255)));
                        push_digit($urandom_range(0, 9), $urandom_range(0, 4) == 0);
                    end
                end
                6, 7:
                begin
                    // Digits right at the overflow guard, then bytes that may be cut off.
                    if ($urandom_range(0, 1) == 1)
                        push_code(MINUS_BYTE);
                    for (int i = 0; i < 18; i++)
                    begin
                        ch = guard_text[i];
                        if (i == 16 && $urandom_range(0, 1) == 1)
                            ch = byte'(ch + 1);
                        push_digit(32'(ch - ASCII_LOW), $urandom_range(0, 3) == 0);
                    end
                    push_digit($urandom_range(0, 9), $urandom_range(0, 3) == 0);
                    repeat ($urandom_range(0, 3))
                    begin
                        case ($urandom_range(0, 2))
                            0: push_digit($urandom_range(0, 9), $urandom_range(0, 1) == 1);
                            1: push_code(MINUS_BYTE);
                            default: push_code(8'($urandom_range(1, 255)));
                        endcase
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 6))
                        push_code(8'($urandom_range(1, 255)));
                end
            endcase
            push_code(TERM_BYTE);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bytes_sent != total_bytes)
            @(negedge clk);
        drain = 0;
        while (expected_values.size() != 0 && drain < 2000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (10) @(negedge clk);
        if (expected_values.size() != 0)
        begin
            error_count++;
            $display("%0d expected values never arrived.", expected_values.size());
        end

        $display("Parsed %0d strings from %0d bytes: %0d negative, %0d stopped by the guard.",
                 strings_parsed, total_bytes, negative_strings, guarded_strings);
        $display("Input held off for %0d cycles; %0d errors counted.",
                 input_stall_cycles, error_count);
        if (error_count == 0)
            $display("tb_decimal_text_to_int64: PASS");
        else
            $display("tb_decimal_text_to_int64: FAIL");
        $finish;
    end

endmodule
